### hdl/heightfield_normal_map_tile_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the normal map tile block.
// ----------------------------------------------------------------------------
`ifndef HEIGHTFIELD_NORMAL_MAP_TILE_MACROS_SVH
`define HEIGHTFIELD_NORMAL_MAP_TILE_MACROS_SVH

// checked outside reset only
`define HNM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// checked on every edge, reset included
`define HNM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) \
      else $error(msg);

`endif

### hdl/hnm_pkg.sv
// ----------------------------------------------------------------------------
// hnm_pkg
// Widths, codes and shared types of the normal map tile block.
// ----------------------------------------------------------------------------
`default_nettype none

package hnm_pkg;

   localparam int ROW_LEN   = 1024;
   localparam int ROW_LIM   = 1024;
   localparam int COL_W     = $clog2(ROW_LEN);
   localparam int ROW_W     = $clog2(ROW_LIM);
   localparam int COUNT_W   = 11;
   localparam int SPACE_W   = 24;
   localparam int ELEV_W    = 32;
   localparam int CHAN_W    = 8;
   localparam int MAG_W     = ELEV_W;
   localparam int PROD_W    = MAG_W + SPACE_W;
   localparam int RED_W     = 24;
   localparam int SQ_W      = 2 * RED_W;
   localparam int SUM_W     = SQ_W + 2;
   localparam int KS_W      = SUM_W + CHAN_W;
   localparam int KSQ_W     = SUM_W + 2 * CHAN_W + 2;
   localparam int Q_W       = SQ_W + 14;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [COUNT_W-1:0] COL_MAX = COUNT_W'(ROW_LEN);
   localparam logic [COUNT_W-1:0] ROW_MAX = COUNT_W'(ROW_LIM);

   localparam logic [CHAN_W-1:0] CH_MID  = 8'd127;
   localparam logic [CHAN_W-1:0] CH_FULL = 8'd255;
   localparam logic [CHAN_W-1:0] K_MAX   = 8'd128;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COL_COUNT = 3'd0,
      CSR_ROW_COUNT = 3'd1,
      CSR_SPACING_X = 3'd2,
      CSR_SPACING_Y = 3'd3,
      CSR_NULL_CODE = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [ELEV_W-1:0] here;
      logic signed [ELEV_W-1:0] right;
      logic signed [ELEV_W-1:0] below;
   } hnm_triple_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } hnm_rgb_type;

endpackage

`default_nettype wire

### hdl/hnm_ifs.sv
// ----------------------------------------------------------------------------
// hnm request and response channels
// Valid/ready channels carrying elevation samples and normal map pixels.
// ----------------------------------------------------------------------------
`default_nettype none

interface hnm_req_if import hnm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [ELEV_W-1:0] elevation;

   modport source (output valid, output elevation, input ready);
   modport sink   (input valid, input elevation, output ready);
endinterface

interface hnm_rsp_if import hnm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CHAN_W-1:0]        red;
   logic [CHAN_W-1:0]        green;
   logic [CHAN_W-1:0]        blue;
   logic [ROW_W-1:0]         pixel_row;
   logic [COL_W-1:0]         pixel_col;
   logic                     last_of_item;
   logic                     tile_done;
   logic signed [ELEV_W-1:0] tile_min;
   logic signed [ELEV_W-1:0] tile_max;
   logic                     tile_has_data;

   modport source (output valid, output red, output green, output blue,
                   output pixel_row, output pixel_col, output last_of_item,
                   output tile_done, output tile_min, output tile_max,
                   output tile_has_data, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input pixel_row, input pixel_col, input last_of_item,
                   input tile_done, input tile_min, input tile_max,
                   input tile_has_data, output ready);
endinterface

`default_nettype wire

### hdl/hnm_ram.sv
// ----------------------------------------------------------------------------
// hnm_ram
// Simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hnm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/hnm_normal.sv
// ----------------------------------------------------------------------------
// hnm_normal
// Iterative unit: one pixel's normal from three samples, as 8-bit channels.
// ----------------------------------------------------------------------------
`default_nettype none

module hnm_normal import hnm_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire hnm_triple_type      samples,
   input  wire logic [SPACE_W-1:0]  dx,
   input  wire logic [SPACE_W-1:0]  dy,
   input  wire logic [ELEV_W-1:0]   null_code,
   output logic                     done,
   output hnm_rgb_type              rgb
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_NORM, ST_SQ, ST_SUM, ST_CHAN
   } state_type;

   state_type         state_ff;
   logic              done_ff;
   hnm_rgb_type       rgb_ff;
   logic [1:0]        step_ff;
   logic [2:0]        bit_ff;
   logic              neg_x_ff, neg_y_ff;
   logic [MAG_W-1:0]  am_ff, bm_ff;
   logic [PROD_W-1:0] comp_ff [3];
   logic [SQ_W-1:0]   sq_ff [3];
   logic [SUM_W-1:0]  s_ff;
   logic [CHAN_W-1:0] k_ff;
   logic [KSQ_W-1:0]  p_ff;
   logic [KS_W-1:0]   ks_ff;

   logic [ELEV_W:0]   diff_a, diff_b;
   logic [ELEV_W:0]   mag_a, mag_b;
   logic              is_null;
   logic [MAG_W-1:0]  op_a;
   logic [SPACE_W-1:0] op_b;
   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] comp_or;
   logic [RED_W-1:0]  sq_op;
   logic [SQ_W-1:0]   sq_prod;
   logic [Q_W-1:0]    q;
   logic [KSQ_W-1:0]  cand_p;
   logic [KS_W-1:0]   cand_ks;
   logic [CHAN_W-1:0] cand_k, k_fin, kp, ch_val;
   logic [CHAN_W:0]   kn;
   logic              neg_ch, ok;
   logic              done_in;

   always_comb begin
      diff_a  = {samples.right[ELEV_W-1], samples.right}
              - {samples.here[ELEV_W-1], samples.here};
      diff_b  = {samples.below[ELEV_W-1], samples.below}
              - {samples.here[ELEV_W-1], samples.here};
      mag_a   = diff_a[ELEV_W] ? -diff_a : diff_a;
      mag_b   = diff_b[ELEV_W] ? -diff_b : diff_b;
      is_null = (samples.here == null_code) || (samples.right == null_code)
             || (samples.below == null_code);

      case (step_ff)
         2'd0: begin
            op_a = am_ff;
            op_b = dy;
         end
         2'd1: begin
            op_a = bm_ff;
            op_b = dx;
         end
         default: begin
            op_a = MAG_W'(dx);
            op_b = dy;
         end
      endcase
      prod    = PROD_W'(op_a) * PROD_W'(op_b);
      comp_or = comp_ff[0] | comp_ff[1] | comp_ff[2];
      sq_op   = comp_ff[step_ff][RED_W-1:0];
      sq_prod = SQ_W'(sq_op) * SQ_W'(sq_op);

      // greedy bit search on k: (k+2^j)^2*S = k^2*S + 2^(j+1)*k*S + 4^j*S
      q       = {sq_ff[step_ff], 14'b0};
      cand_k  = k_ff | (CHAN_W'(1) << bit_ff);
      cand_p  = p_ff + (KSQ_W'(ks_ff) << ({1'b0, bit_ff} + 4'd1))
              + (KSQ_W'(s_ff) << {bit_ff, 1'b0});
      cand_ks = ks_ff + (KS_W'(s_ff) << bit_ff);
      case (step_ff)
         2'd0:    neg_ch = neg_x_ff;
         2'd1:    neg_ch = neg_y_ff;
         default: neg_ch = 1'b0;
      endcase
      ok    = neg_ch ? (cand_p < KSQ_W'(q)) : (cand_p <= KSQ_W'(q));
      k_fin = ok ? cand_k : k_ff;
      kp    = (k_fin > K_MAX) ? K_MAX : k_fin;
      if (q == '0) begin
         kn = '0;
      end else begin
         kn = {1'b0, k_fin} + 9'd1;
      end
      if (!neg_ch) begin
         ch_val = CH_MID + kp;
      end else if (kn >= {1'b0, K_MAX}) begin
         ch_val = '0;
      end else begin
         ch_val = CH_MID - kn[CHAN_W-1:0];
      end
      done_in = ((state_ff == ST_IDLE) && start && is_null)
             || ((state_ff == ST_CHAN) && (bit_ff == 3'd0) && (step_ff == 2'd2));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= done_in;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  if (is_null) begin
                     rgb_ff  <= '{red: CH_MID, green: CH_MID, blue: CH_FULL};
                  end else begin
                     am_ff    <= mag_a[MAG_W-1:0];
                     bm_ff    <= mag_b[MAG_W-1:0];
                     neg_x_ff <= !diff_a[ELEV_W] && (diff_a != '0);
                     neg_y_ff <= !diff_b[ELEV_W] && (diff_b != '0);
                     step_ff  <= 2'd0;
                     state_ff <= ST_MUL;
                  end
               end
            end
            ST_MUL: begin
               comp_ff[step_ff] <= prod;
               if (step_ff == 2'd2) begin
                  step_ff  <= 2'd0;
                  state_ff <= ST_NORM;
               end else begin
                  step_ff <= step_ff + 2'd1;
               end
            end
            ST_NORM: begin
               if (|comp_or[PROD_W-1:32]) begin
                  for (int i = 0; i < 3; i++) comp_ff[i] <= comp_ff[i] >> 8;
               end else if (|comp_or[PROD_W-1:RED_W]) begin
                  for (int i = 0; i < 3; i++) comp_ff[i] <= comp_ff[i] >> 1;
               end else begin
                  state_ff <= ST_SQ;
               end
            end
            ST_SQ: begin
               sq_ff[step_ff] <= sq_prod;
               if (step_ff == 2'd2) begin
                  step_ff  <= 2'd0;
                  state_ff <= ST_SUM;
               end else begin
                  step_ff <= step_ff + 2'd1;
               end
            end
            ST_SUM: begin
               s_ff     <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
               k_ff     <= '0;
               p_ff     <= '0;
               ks_ff    <= '0;
               bit_ff   <= 3'd7;
               state_ff <= ST_CHAN;
            end
            ST_CHAN: begin
               if (bit_ff == 3'd0) begin
                  case (step_ff)
                     2'd0:    rgb_ff.red   <= ch_val;
                     2'd1:    rgb_ff.green <= ch_val;
                     default: rgb_ff.blue  <= ch_val;
                  endcase
                  k_ff   <= '0;
                  p_ff   <= '0;
                  ks_ff  <= '0;
                  bit_ff <= 3'd7;
                  if (step_ff == 2'd2) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     step_ff <= step_ff + 2'd1;
                  end
               end else begin
                  if (ok) begin
                     k_ff  <= cand_k;
                     p_ff  <= cand_p;
                     ks_ff <= cand_ks;
                  end
                  bit_ff <= bit_ff - 3'd1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign rgb  = rgb_ff;

endmodule

`default_nettype wire

### hdl/heightfield_normal_map_tile.sv
// ----------------------------------------------------------------------------
// heightfield_normal_map_tile
// Streams a tile's elevations in raster order and returns normal map pixels
// plus the tile's running non-null minimum and maximum.
// ----------------------------------------------------------------------------
// Usage:
//  - req_if carries one elevation per request, raster order. Each request
//    returns zero to three pixels on rsp_if; last_of_item marks the final one
//    and tile_done the tile's final pixel.
//  - csr port writes col_count, row_count, spacing_x, spacing_y, null_code;
//    write only while idle.
//  - One request at a time. A request passes through the line-store
//    reads (row RAM with one read port, reads at column c and c+1) and a
//    dispatch state per pixel, then each pixel goes through the shared
//    normal unit: a null pixel gets a fixed colour, else the unit does
//    3 multiplies, up to 11 normalize shifts and a check, 3 squares, a sum
//    and 3 x 8 channel search steps; the result is then captured and held
//    in the output register until rsp_if takes it.
//  - When rsp_if stalls the pixel holds in the output register and no new
//    request is taken until it drains.
//  - Reset clears indexes, statistics and registers to their defaults; the
//    row store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "heightfield_normal_map_tile_macros.svh"

module heightfield_normal_map_tile import hnm_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   hnm_req_if.sink                    req_if,
   hnm_rsp_if.source                  rsp_if,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_RD_A, ST_RD_B, ST_JOB, ST_WAIT, ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      JOB_UP = 2'd0, JOB_LEFT = 2'd1, JOB_CORNER = 2'd2
   } job_type;

   // config
   logic [COUNT_W-1:0] col_count_ff, row_count_ff;
   logic [SPACE_W-1:0] spacing_x_ff, spacing_y_ff;
   logic [ELEV_W-1:0]  null_code_ff;

   state_type                state_ff;
   job_type                  job_ff;
   logic [2:0]               pending_ff;
   logic [ROW_W-1:0]         row_idx_ff, row_ff;
   logic [COL_W-1:0]         col_idx_ff, col_ff;
   logic                     last_row_ff, last_col_ff;
   logic signed [ELEV_W-1:0] elev_ff, left_ff, left_old_ff, above_ff, right_ff;
   logic signed [ELEV_W-1:0] run_min_ff, run_max_ff, snap_min_ff, snap_max_ff;
   logic                     seen_ff, snap_seen_ff;
   logic                     eng_start_ff;
   logic                     rsp_valid_ff, rsp_last_ff, rsp_tile_done_ff;
   hnm_rgb_type              rsp_rgb_ff;
   logic [ROW_W-1:0]         rsp_row_ff;
   logic [COL_W-1:0]         rsp_col_ff;

   logic [COUNT_W-1:0]       cols_sat, rows_sat;
   logic [SPACE_W-1:0]       dx, dy;
   logic                     accept, last_col, last_row, tile_end, e_null;
   logic signed [ELEV_W-1:0] elev, new_min, new_max;
   logic                     ram_rd_en, ram_wr_en;
   logic [COL_W-1:0]         ram_rd_addr;
   logic [ELEV_W-1:0]        ram_rd_data;
   hnm_triple_type           job_samples;
   logic [ROW_W-1:0]         job_row;
   logic [COL_W-1:0]         job_col;
   logic                     eng_done;
   hnm_rgb_type              eng_rgb;
   logic [2:0]               pend_next;
   job_type                  job_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= COL_MAX;
         row_count_ff <= ROW_MAX;
         spacing_x_ff <= SPACE_W'(1000);
         spacing_y_ff <= SPACE_W'(1000);
         null_code_ff <= ELEV_W'(1000000000);
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_COL_COUNT: col_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_ROW_COUNT: row_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_SPACING_X: spacing_x_ff <= csr_wdata[SPACE_W-1:0];
            CSR_SPACING_Y: spacing_y_ff <= csr_wdata[SPACE_W-1:0];
            CSR_NULL_CODE: null_code_ff <= csr_wdata[ELEV_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (col_count_ff == '0) begin
         cols_sat = COUNT_W'(1);
      end else if (col_count_ff > COL_MAX) begin
         cols_sat = COL_MAX;
      end else begin
         cols_sat = col_count_ff;
      end
      if (row_count_ff == '0) begin
         rows_sat = COUNT_W'(1);
      end else if (row_count_ff > ROW_MAX) begin
         rows_sat = ROW_MAX;
      end else begin
         rows_sat = row_count_ff;
      end
      dx = (spacing_x_ff == '0) ? SPACE_W'(1) : spacing_x_ff;
      dy = (spacing_y_ff == '0) ? SPACE_W'(1) : spacing_y_ff;

      accept   = req_if.valid && (state_ff == ST_IDLE);
      elev     = req_if.elevation;
      last_col = (COUNT_W'(col_idx_ff) + COUNT_W'(1)) >= cols_sat;
      last_row = (COUNT_W'(row_idx_ff) + COUNT_W'(1)) >= rows_sat;
      tile_end = last_col && last_row;
      e_null   = (elev == null_code_ff);
      new_min  = (!seen_ff || (elev < run_min_ff)) ? elev : run_min_ff;
      new_max  = (!seen_ff || (elev > run_max_ff)) ? elev : run_max_ff;

      ram_rd_en   = accept || (state_ff == ST_RD_A);
      ram_rd_addr = accept ? col_idx_ff : col_ff + COL_W'(1);
      ram_wr_en   = (state_ff == ST_RD_B);

      case (job_ff)
         JOB_UP: begin
            job_samples = '{here: above_ff, right: last_col_ff ? above_ff : right_ff,
                            below: elev_ff};
            job_row     = row_ff - ROW_W'(1);
            job_col     = col_ff;
         end
         JOB_LEFT: begin
            job_samples = '{here: left_old_ff, right: elev_ff, below: left_old_ff};
            job_row     = row_ff;
            job_col     = col_ff - COL_W'(1);
         end
         default: begin
            job_samples = '{here: elev_ff, right: elev_ff, below: elev_ff};
            job_row     = row_ff;
            job_col     = col_ff;
         end
      endcase

      if (pending_ff[JOB_UP]) begin
         job_next = JOB_UP;
      end else if (pending_ff[JOB_LEFT]) begin
         job_next = JOB_LEFT;
      end else begin
         job_next = JOB_CORNER;
      end
      pend_next = pending_ff & ~(3'b001 << job_next);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_idx_ff   <= '0;
         col_idx_ff   <= '0;
         run_min_ff   <= '0;
         run_max_ff   <= '0;
         seen_ff      <= 1'b0;
         pending_ff   <= '0;
         eng_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         eng_start_ff <= (state_ff == ST_JOB) && (pending_ff != '0);
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  elev_ff     <= elev;
                  row_ff      <= row_idx_ff;
                  col_ff      <= col_idx_ff;
                  last_row_ff <= last_row;
                  last_col_ff <= last_col;
                  left_old_ff <= left_ff;
                  left_ff     <= elev;
                  if (!e_null) begin
                     snap_min_ff  <= new_min;
                     snap_max_ff  <= new_max;
                     snap_seen_ff <= 1'b1;
                  end else begin
                     snap_min_ff  <= run_min_ff;
                     snap_max_ff  <= run_max_ff;
                     snap_seen_ff <= seen_ff;
                  end
                  if (tile_end) begin
                     run_min_ff <= '0;
                     run_max_ff <= '0;
                     seen_ff    <= 1'b0;
                  end else if (!e_null) begin
                     run_min_ff <= new_min;
                     run_max_ff <= new_max;
                     seen_ff    <= 1'b1;
                  end
                  if (last_col) begin
                     col_idx_ff <= '0;
                     row_idx_ff <= last_row ? '0 : row_idx_ff + ROW_W'(1);
                  end else begin
                     col_idx_ff <= col_idx_ff + COL_W'(1);
                  end
                  state_ff <= ST_RD_A;
               end
            end
            ST_RD_A: begin
               above_ff <= ram_rd_data;
               state_ff <= ST_RD_B;
            end
            ST_RD_B: begin
               right_ff   <= ram_rd_data;
               pending_ff <= {last_row_ff && last_col_ff,
                              last_row_ff && (col_ff != '0),
                              row_ff != '0};
               state_ff   <= ST_JOB;
            end
            ST_JOB: begin
               if (pending_ff == '0) begin
                  state_ff <= ST_IDLE;
               end else begin
                  job_ff     <= job_next;
                  pending_ff <= pend_next;
                  state_ff   <= ST_WAIT;
               end
            end
            ST_WAIT: begin
               if (eng_done) begin
                  rsp_rgb_ff       <= eng_rgb;
                  rsp_row_ff       <= job_row;
                  rsp_col_ff       <= job_col;
                  rsp_last_ff      <= (pending_ff == '0);
                  rsp_tile_done_ff <= (job_ff == JOB_CORNER);
                  rsp_valid_ff     <= 1'b1;
                  state_ff         <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (rsp_if.ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_JOB;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   hnm_ram #(
      .WIDTH (ELEV_W),
      .DEPTH (ROW_LEN)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (col_ff),
      .wr_data (elev_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   hnm_normal u_normal (
      .clock     (clock),
      .reset     (reset),
      .start     (eng_start_ff),
      .samples   (job_samples),
      .dx        (dx),
      .dy        (dy),
      .null_code (null_code_ff),
      .done      (eng_done),
      .rgb       (eng_rgb)
   );

   assign req_if.ready         = (state_ff == ST_IDLE);
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.red           = rsp_rgb_ff.red;
   assign rsp_if.green         = rsp_rgb_ff.green;
   assign rsp_if.blue          = rsp_rgb_ff.blue;
   assign rsp_if.pixel_row     = rsp_row_ff;
   assign rsp_if.pixel_col     = rsp_col_ff;
   assign rsp_if.last_of_item  = rsp_last_ff;
   assign rsp_if.tile_done     = rsp_tile_done_ff;
   assign rsp_if.tile_min      = snap_min_ff;
   assign rsp_if.tile_max      = snap_max_ff;
   assign rsp_if.tile_has_data = snap_seen_ff;

   `HNM_ASSERT(a_no_req_while_rsp, accept |-> !rsp_valid_ff, "request taken with pixel pending")
   `HNM_ASSERT(a_done_is_last, (rsp_valid_ff && rsp_tile_done_ff) |-> rsp_last_ff, "tile end not last")
   `HNM_ASSERT(a_tile_wrap, (accept && tile_end) |=> (row_idx_ff == '0 && col_idx_ff == '0 && !seen_ff), "no wrap at tile end")
   `HNM_ASSERT(a_eng_done_wait, eng_done |-> (state_ff == ST_WAIT), "normal unit done out of turn")
   `HNM_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == ST_IDLE && !rsp_valid_ff), "not idle after reset")

endmodule

`default_nettype wire
